/* src/asr_pkg.sv */
package asr_pkg;

  // ring geometry
  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 11;
  localparam int TIME_W    = 16;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]  SLOT_COUNT_RST  = 11'd1024;
  localparam logic [TIME_W-1:0] LIFETIME_RST    = 16'd50000;
  localparam logic [TIME_W-1:0] WRAP_PERIOD_RST = 16'd60000;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_LIFETIME    = 2'd1;
  localparam logic [1:0] CFG_WRAP_PERIOD = 2'd2;

  // request types
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_SLOT = 2'd0;
  localparam logic [1:0] KIND_WIPE = 2'd1;
  localparam logic [1:0] KIND_MOD  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] spawn_ms;
    logic [TIME_W-1:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [SLOT_W-1:0] range_start;
    logic [CNT_W-1:0]  range_count;
    logic              last;
  } out_word_t;

  // one ring entry as stored in the slot memory
  typedef struct packed {
    logic              live;
    logic [TIME_W-1:0] spawn;
  } slot_ent_t;

endpackage

/* src/aging_slot_ring_dirty_tracker.sv */
// Ring of time-stamped slots with dirty-range reporting. After reset the block
// clears all MAX_SLOTS (1024) entries of the slot memory with busy high; a
// word is accepted when start is high and busy is low. On an add busy stays
// low, the next word may follow in the next cycle, and the slot result
// appears on out_word in the cycle after acceptance. A frame walks the
// oldest slots through the slot memory, reading each slot examined and then
// checking it and writing it back, and keeps busy high while it runs; the
// walk is skipped when no slot is tracked. It emits at most one result per
// cycle, at most five in all, the last one marked. Results are one-cycle
// strobes on out_valid and cannot be held off.
module aging_slot_ring_dirty_tracker
  import asr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              out_valid,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_WEND  = 3'd4;
  localparam logic [2:0] S_MOD1  = 3'd5;
  localparam logic [2:0] S_MOD2  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  slot_count_r, slot_count_nxt;
  logic [TIME_W-1:0] lifetime_r, lifetime_nxt;
  logic [TIME_W-1:0] wrap_r, wrap_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic              none_r, none_nxt;
  logic [CNT_W-1:0]  next_r, next_nxt;
  logic [CNT_W-1:0]  mod_r, mod_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [CNT_W-1:0]  wcnt_r, wcnt_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // slot memory
  slot_ent_t         mem [MAX_SLOTS];
  slot_ent_t         rdata_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_ent_t         mem_wdata;

  logic [CNT_W-1:0]  eff_c;
  logic [CNT_W-1:0]  n_eff;
  logic [SLOT_W-1:0] add_slot;
  logic [CNT_W-1:0]  add_slot_p1;
  logic [CNT_W-1:0]  old_p1;
  logic [TIME_W:0]   age;
  logic [TIME_W+1:0] age_x;
  logic [TIME_W+1:0] age_lim;
  logic              expired;
  logic [CNT_W:0]    tail_start;

  // effective slot count: zero acts as one, clamp at the ring size
  always_comb begin
    if (slot_count_r == '0) begin
      eff_c = CNT_W'(1);
    end else if (slot_count_r > CNT_W'(MAX_SLOTS)) begin
      eff_c = CNT_W'(MAX_SLOTS);
    end else begin
      eff_c = slot_count_r;
    end
  end

  assign n_eff       = (next_r < eff_c) ? next_r : eff_c;
  assign add_slot    = (next_r >= eff_c) ? '0 : next_r[SLOT_W-1:0];
  assign add_slot_p1 = {1'b0, add_slot} + CNT_W'(1);
  assign old_p1      = {1'b0, oldest_r} + CNT_W'(1);
  assign tail_start  = {1'b0, n_eff} + {1'b0, eff_c} - {1'b0, mod_r};

  // signed age test, with the wrapped-clock limit for negative ages
  assign age     = {1'b0, now_r} - {1'b0, rdata_r.spawn};
  assign age_x   = {age[TIME_W], age};
  assign age_lim = age[TIME_W] ? ({2'b00, lifetime_r} - {2'b00, wrap_r})
                               : {2'b00, lifetime_r};
  assign expired = $signed(age_x) > $signed(age_lim);

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    slot_count_nxt = slot_count_r;
    lifetime_nxt   = lifetime_r;
    wrap_nxt       = wrap_r;
    oldest_nxt     = oldest_r;
    none_nxt       = none_r;
    next_nxt       = next_r;
    mod_nxt        = mod_r;
    clr_nxt        = clr_r;
    ws_nxt         = ws_r;
    wcnt_nxt       = wcnt_r;
    now_nxt        = now_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_waddr      = add_slot;
    mem_wdata      = '{live: 1'b1, spawn: in_word.spawn_ms};

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_COUNT:  slot_count_nxt = cfg_wdata[CNT_W-1:0];
        CFG_LIFETIME:    lifetime_nxt   = cfg_wdata;
        CFG_WRAP_PERIOD: wrap_nxt       = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      // clear every live bit after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(MAX_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_word.req_type == REQ_ADD) begin
            // take the next slot and report it
            mem_we = 1'b1;
            if (none_r) begin
              oldest_nxt = add_slot;
              none_nxt   = 1'b0;
            end else if (oldest_r == add_slot) begin
              oldest_nxt = (add_slot_p1 == eff_c) ? '0 : add_slot_p1[SLOT_W-1:0];
            end
            next_nxt = add_slot_p1;
            mod_nxt  = (mod_r < eff_c) ? mod_r + CNT_W'(1) : eff_c;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{result_kind: KIND_SLOT, range_start: add_slot,
                              range_count: CNT_W'(1), last: 1'b1};
          end else begin
            // frame: start the walk at the oldest slot
            now_nxt  = in_word.now_time;
            wcnt_nxt = '0;
            if (none_r) begin
              state_nxt = S_MOD1;
            end else begin
              if ({1'b0, oldest_r} >= eff_c) begin
                oldest_nxt = '0;
                ws_nxt     = '0;
              end else begin
                ws_nxt = oldest_r;
              end
              state_nxt = S_RD;
            end
          end
        end
      end

      S_RD: begin
        state_nxt = S_CHK;
      end

      // check one slot, retire it if its age has run out
      S_CHK: begin
        if (!rdata_r.live) begin
          none_nxt  = 1'b1;
          state_nxt = S_WEND;
        end else if (!expired) begin
          state_nxt = S_WEND;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = oldest_r;
          mem_wdata = '{live: 1'b0, spawn: rdata_r.spawn};
          state_nxt = S_RD;
          if (old_p1 == eff_c) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{result_kind: KIND_WIPE, range_start: ws_r,
                              range_count: wcnt_r + CNT_W'(1), last: 1'b0};
            oldest_nxt = '0;
            ws_nxt     = '0;
            wcnt_nxt   = '0;
          end else begin
            oldest_nxt = old_p1[SLOT_W-1:0];
            wcnt_nxt   = wcnt_r + CNT_W'(1);
          end
        end
      end

      // report the remaining wiped range
      S_WEND: begin
        if (wcnt_r != '0) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{result_kind: KIND_WIPE, range_start: ws_r,
                            range_count: wcnt_r, last: 1'b0};
        end
        state_nxt = S_MOD1;
      end

      // modified range, or its head part when it wraps
      S_MOD1: begin
        state_nxt = S_DONE;
        if (mod_r >= eff_c) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{result_kind: KIND_MOD, range_start: '0,
                            range_count: eff_c, last: 1'b0};
        end else if (mod_r > n_eff) begin
          state_nxt = S_MOD2;
          if (n_eff != '0) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{result_kind: KIND_MOD, range_start: '0,
                              range_count: n_eff, last: 1'b0};
          end
        end else if (mod_r != '0) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{result_kind: KIND_MOD,
                            range_start: SLOT_W'(n_eff - mod_r),
                            range_count: mod_r, last: 1'b0};
        end
      end

      // tail part of a wrapped modified range
      S_MOD2: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{result_kind: KIND_MOD,
                          range_start: tail_start[SLOT_W-1:0],
                          range_count: mod_r - n_eff, last: 1'b0};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{result_kind: KIND_DONE, range_start: '0,
                          range_count: '0, last: 1'b1};
        mod_nxt   = '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      slot_count_r <= SLOT_COUNT_RST;
      lifetime_r   <= LIFETIME_RST;
      wrap_r       <= WRAP_PERIOD_RST;
      oldest_r     <= '0;
      none_r       <= 1'b1;
      next_r       <= '0;
      mod_r        <= '0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      lifetime_r   <= lifetime_nxt;
      wrap_r       <= wrap_nxt;
      oldest_r     <= oldest_nxt;
      none_r       <= none_nxt;
      next_r       <= next_nxt;
      mod_r        <= mod_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    ws_r       <= ws_nxt;
    wcnt_r     <= wcnt_nxt;
    now_r      <= now_nxt;
    out_word_r <= out_word_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[oldest_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // an add is answered with its slot in the next cycle
  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.req_type == REQ_ADD) |=>
      out_valid && (out_word.result_kind == KIND_SLOT) && out_word.last)
    else $error("add not answered with a slot result");

  // a frame never answers in the cycle right after acceptance
  a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.req_type == REQ_FRAME) |=> !out_valid)
    else $error("frame result too early");

  // only slot and done results end a word's output
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |->
      (out_word.result_kind == KIND_SLOT) || (out_word.result_kind == KIND_DONE))
    else $error("last flag on a range result");

  // ranges are never empty and never exceed the ring
  a_range_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_word.result_kind == KIND_WIPE) ||
                  (out_word.result_kind == KIND_MOD)) |->
      (out_word.range_count != '0) && (out_word.range_count <= CNT_W'(MAX_SLOTS)))
    else $error("bad range size");

  // the done marker ends the frame and the block is then free
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.result_kind == KIND_DONE) |-> !busy)
    else $error("block busy after frame done");

endmodule

/* tb/tb_aging_slot_ring_dirty_tracker.sv */
`timescale 1ns / 1ps

module tb_aging_slot_ring_dirty_tracker;
  import asr_pkg::*;

  // tracks ring state and holds the result words still owed by the block
  class ring_scoreboard;
    int unsigned       slot_count;
    int unsigned       lifetime;
    int unsigned       wrap_period;
    logic [TIME_W-1:0] spawn_at [MAX_SLOTS];
    bit                live [MAX_SLOTS];
    int unsigned       oldest;
    bit                oldest_none;
    int unsigned       next_slot;
    int unsigned       modified;
    out_word_t         owed [$];
    int                errors;

    function new();
      slot_count  = 32'(SLOT_COUNT_RST);
      lifetime    = 32'(LIFETIME_RST);
      wrap_period = 32'(WRAP_PERIOD_RST);
      foreach (live[i]) begin
        live[i]     = 1'b0;
        spawn_at[i] = '0;
      end
      oldest      = 0;
      oldest_none = 1'b1;
      next_slot   = 0;
      modified    = 0;
      errors      = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [TIME_W-1:0] val);
      case (idx)
        CFG_SLOT_COUNT:  slot_count  = 32'(val[CNT_W-1:0]);
        CFG_LIFETIME:    lifetime    = 32'(val);
        CFG_WRAP_PERIOD: wrap_period = 32'(val);
        default: ;
      endcase
    endfunction

    // slots actually in use after clamping
    function int unsigned ring_size();
      if (slot_count == 0) return 1;
      if (slot_count > MAX_SLOTS) return MAX_SLOTS;
      return slot_count;
    endfunction

    // signed age test, with wrapped clock when age is negative
    function bit aged_out(input int unsigned s, input logic [TIME_W-1:0] now);
      int age;
      age = int'(now) - int'(spawn_at[s]);
      if (age >= 0) return age > int'(lifetime);
      return age > int'(lifetime) - int'(wrap_period);
    endfunction

    function out_word_t make_word(input logic [1:0] kind, input int unsigned first,
                                  input int unsigned count, input logic fin);
      out_word_t r;
      r.result_kind = kind;
      r.range_start = SLOT_W'(first);
      r.range_count = CNT_W'(count);
      r.last        = fin;
      return r;
    endfunction

    // empty ranges are never reported
    function void owe_range(input logic [1:0] kind, input int unsigned first,
                            input int unsigned count);
      if (count != 0) owed.push_back(make_word(kind, first, count, 1'b0));
    endfunction

    // accepted input word: update ring and queue its results
    function void note_word(input in_word_t w);
      int unsigned c, slot, ws, we, m, n;
      c = ring_size();
      if (w.req_type == REQ_ADD) begin
        if (next_slot >= c) next_slot = 0;
        slot           = next_slot;
        spawn_at[slot] = w.spawn_ms;
        live[slot]     = 1'b1;
        if (oldest_none) begin
          oldest      = slot;
          oldest_none = 1'b0;
        end else if (oldest == slot) begin
          oldest = slot + 1;
          if (oldest == c) oldest = 0;
        end
        next_slot = slot + 1;
        modified  = (modified < c) ? modified + 1 : c;
        owed.push_back(make_word(KIND_SLOT, slot, 1, 1'b1));
      end else begin
        // walk the oldest pointer, retiring expired slots
        if (!oldest_none && oldest >= c) oldest = 0;
        ws = oldest;
        we = oldest;
        while (!oldest_none) begin
          if (!live[oldest]) begin
            oldest_none = 1'b1;
            break;
          end
          if (!aged_out(oldest, w.now_time)) break;
          live[oldest] = 1'b0;
          oldest++;
          we++;
          if (oldest == c) begin
            owe_range(KIND_WIPE, ws, we - ws);
            oldest = 0;
            ws     = 0;
            we     = 0;
          end
        end
        if (!oldest_none || we != ws) owe_range(KIND_WIPE, ws, we - ws);
        // dirty ranges since the previous frame
        m = modified;
        n = (next_slot < c) ? next_slot : c;
        if (m >= c) begin
          owe_range(KIND_MOD, 0, c);
        end else if (m > n) begin
          owe_range(KIND_MOD, 0, n);
          owe_range(KIND_MOD, n + c - m, m - n);
        end else if (m > 0) begin
          owe_range(KIND_MOD, n - m, m);
        end
        modified = 0;
        owed.push_back(make_word(KIND_DONE, 0, 0, 1'b1));
      end
    endfunction

    // result word seen on the output strobe
    function void check_word(input out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: kind %0d start %0d count %0d last %0b",
                   got.result_kind, got.range_start, got.range_count, got.last);
      end else begin
        want = owed.pop_front();
        if (got.result_kind !== want.result_kind || got.range_start !== want.range_start ||
            got.range_count !== want.range_count || got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected kind %0d start %0d count %0d last %0b, %s%0d %0d %0d %0b",
                     want.result_kind, want.range_start, want.range_count, want.last,
                     "got ", got.result_kind, got.range_start, got.range_count, got.last);
        end
      end
    endfunction

    function void close_out();
      if (owed.size() != 0) begin
        errors += owed.size();
        $display("%0d expected words never arrived", owed.size());
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_word_t          in_word;
  logic              out_valid;
  out_word_t         out_word;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [TIME_W-1:0] cfg_wdata;

  ring_scoreboard    sb;
  int unsigned       clock_ms;

  aging_slot_ring_dirty_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // check results first, then note the word accepted at this edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) sb.check_word(out_word);
      if (start === 1'b1 && busy === 1'b0) sb.note_word(in_word);
    end
  end

  function automatic in_word_t add_word(input logic [TIME_W-1:0] spawn);
    in_word_t w;
    w.req_type = REQ_ADD;
    w.spawn_ms = spawn;
    w.now_time = TIME_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t frame_word(input logic [TIME_W-1:0] now);
    in_word_t w;
    w.req_type = REQ_FRAME;
    w.spawn_ms = TIME_W'($urandom);
    w.now_time = now;
    return w;
  endfunction

  // hold the word until the block takes it
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // pause the sender until every owed result has come
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
  endtask

  // drained and not busy, safe for register writes
  task automatic quiesce();
    drain_results();
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input int unsigned sc, input int unsigned lt,
                           input int unsigned wp);
    quiesce();
    cfg_write(CFG_SLOT_COUNT, TIME_W'(sc));
    cfg_write(CFG_LIFETIME, TIME_W'(lt));
    cfg_write(CFG_WRAP_PERIOD, TIME_W'(wp));
    cfg_we <= 1'b0;
  endtask

  // random words following a running clock, with some noise
  task automatic run_phase(input int items, input int idle_pct, input int unsigned lt,
                           input int unsigned wp);
    in_word_t w;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(29) == 0) drain_results();
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      clock_ms = (clock_ms + $urandom_range(0, lt / 3 + 2)) % wp;
      if ($urandom_range(9) == 0) begin
        w.req_type = 1'($urandom_range(1));
        w.spawn_ms = TIME_W'($urandom);
        w.now_time = TIME_W'($urandom);
      end else if ($urandom_range(99) < 70) begin
        w = add_word(TIME_W'(clock_ms));
      end else begin
        w = frame_word(TIME_W'(clock_ms));
      end
      send_word(w);
    end
  endtask

  initial begin
    int unsigned sc, lt, wp;
    int          guard;
    sb        = new();
    clock_ms  = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    quiesce();

    // reset settings: empty frame, plain and wrapped aging
    send_word(frame_word(16'h0000));
    send_word(add_word(16'd100));
    send_word(add_word(16'hFFFF));
    send_word(frame_word(16'd100));
    send_word(frame_word(16'hFFFF));
    send_word(frame_word(16'h0000));
    send_word(frame_word(16'd60000));

    // tiny ring: overwrite of oldest, saturation, split wipe and dirty ranges
    configure(3, 0, 1);
    repeat (4) send_word(add_word(16'd5));
    send_word(frame_word(16'd5));
    send_word(frame_word(16'd6));
    send_word(add_word(16'd5));
    send_word(add_word(16'd7));
    send_word(frame_word(16'd6));
    send_word(add_word(16'd9));
    send_word(add_word(16'd9));
    send_word(frame_word(16'd10));

    // zero slot count acts as one, widest lifetime and wrap
    configure(0, 65535, 65535);
    send_word(add_word(16'h0000));
    send_word(add_word(16'hFFFF));
    send_word(frame_word(16'hFFFE));

    // random phases over several settings and idle rates
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       sc = $urandom_range(2, 8);
        1:       sc = $urandom_range(9, 40);
        2:       sc = 0;
        3:       sc = 2047;
        4:       sc = $urandom_range(1, 6);
        5:       sc = MAX_SLOTS;
        default: sc = $urandom_range(3, 12);
      endcase
      case ($urandom_range(3))
        0:       lt = 0;
        1:       lt = 65535;
        default: lt = $urandom_range(20, 800);
      endcase
      case ($urandom_range(3))
        0:       wp = 1;
        1:       wp = 65535;
        default: wp = $urandom_range(200, 5000);
      endcase
      configure(sc, lt, wp);
      run_phase(30, (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 51 : 16), lt, wp);
    end

    // wait out the remaining results
    start <= 1'b0;
    guard = 0;
    while (sb.owed.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #24000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
